@@ sv/nlt_pkg.sv @@
// shared types and constants for the neighbor liveness table
package nlt_pkg;

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 8;
  localparam int POS_W   = 8;
  localparam int ST_W    = 3;
  localparam int MS_W    = 20;
  localparam int SLOT_W  = 3;
  localparam int CNT_W   = 4;
  localparam int CFG_I_W = 2;

  typedef enum logic [1:0] {
    ACT_DISCOVER = 2'd0,
    ACT_STATUS   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_LOOKUP   = 2'd3
  } action_t;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_OFFLINE  = 3'd1;
  localparam logic [ST_W-1:0] ST_LAST     = 3'd5;

  localparam logic [CFG_I_W-1:0] CFG_OWN_ID    = 2'd0;
  localparam logic [CFG_I_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFG_I_W-1:0] CFG_INTERVAL  = 2'd2;

  localparam logic [ID_W-1:0] OWN_ID_RST   = 8'd1;
  localparam logic [MS_W-1:0] TIMEOUT_RST  = 20'd15000;
  localparam logic [MS_W-1:0] INTERVAL_RST = 20'd5000;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  pos;
    logic [ST_W-1:0]   state;
    logic [TIME_W-1:0] heard;
    logic              disc;
  } entry_t;

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    logic              created;
    logic              send_reply;
    logic              state_changed;
    logic [ST_W-1:0]   previous_state;
    logic [CNT_W-1:0]  offline_count;
    logic              send_broadcast;
    logic              found;
    logic [ADDR_W-1:0] found_address;
    logic [ID_W-1:0]   found_id;
    logic [ST_W-1:0]   found_state;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WRITE,
    S_DONE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
    logic publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic echo_in;
    logic is_find;
    logic rd_last;
    logic out_free;
  } ctl_sts_t;

endpackage

@@ sv/nlt_if.sv @@
// handshake channels for items and results
interface nlt_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [nlt_pkg::TIME_W-1:0] now_ms;
  logic [nlt_pkg::ADDR_W-1:0] peer_address;
  logic [nlt_pkg::ID_W-1:0]   peer_id;
  logic [nlt_pkg::POS_W-1:0]  peer_position;
  logic [nlt_pkg::ST_W-1:0]   peer_state;

  modport source (output valid, action, now_ms, peer_address, peer_id, peer_position,
                  peer_state, input ready);
  modport sink (input valid, action, now_ms, peer_address, peer_id, peer_position,
                peer_state, output ready);
endinterface

interface nlt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [nlt_pkg::SLOT_W-1:0] slot;
  logic                       created;
  logic                       send_reply;
  logic                       state_changed;
  logic [nlt_pkg::ST_W-1:0]   previous_state;
  logic [nlt_pkg::CNT_W-1:0]  offline_count;
  logic                       send_broadcast;
  logic                       found;
  logic [nlt_pkg::ADDR_W-1:0] found_address;
  logic [nlt_pkg::ID_W-1:0]   found_id;
  logic [nlt_pkg::ST_W-1:0]   found_state;

  modport source (output valid, accepted, slot, created, send_reply, state_changed,
                  previous_state, offline_count, send_broadcast, found, found_address,
                  found_id, found_state, input ready);
  modport sink (input valid, accepted, slot, created, send_reply, state_changed,
                previous_state, offline_count, send_broadcast, found, found_address,
                found_id, found_state, output ready);
endinterface

@@ sv/neighbor_liveness_table_core.sv @@
// neighbor liveness table: top level joining sequencer and datapath
//
//   channel  dir  handshake        carries
//   req      in   valid/ready      action, now_ms, peer_address, peer_id, peer_position, peer_state
//   rsp      out  valid/ready      one result per item, fields unused by the action are zero
//   cfg      in   cfg_we           cfg_index selects own id, silence timeout, broadcast interval
//
// a discover or status item runs through the scan, drain and commit states before its result is
// published; a tick or lookup skips the commit, and an echo goes straight to publishing. the
// scan reads one entry of the entry ram per cycle.
// one item is in work at a time; the next transfer is taken once the result has moved
// to the output register, which holds it while rsp is stalled.
// synchronous reset empties the table and restores the register defaults at once.
module neighbor_liveness_table_core #(
  parameter int TABLE_SLOTS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  nlt_in_if.sink                      req,
  nlt_out_if.source                   rsp,
  input  logic                        cfg_we,
  input  logic [nlt_pkg::CFG_I_W-1:0] cfg_index,
  input  logic [nlt_pkg::MS_W-1:0]    cfg_data
);
  import nlt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  result_t  res;

  nlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nlt_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (req.action),
    .now_ms        (req.now_ms),
    .peer_address  (req.peer_address),
    .peer_id       (req.peer_id),
    .peer_position (req.peer_position),
    .peer_state    (req.peer_state),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .res           (res)
  );

  assign rsp.accepted       = res.accepted;
  assign rsp.slot           = res.slot;
  assign rsp.created        = res.created;
  assign rsp.send_reply     = res.send_reply;
  assign rsp.state_changed  = res.state_changed;
  assign rsp.previous_state = res.previous_state;
  assign rsp.offline_count  = res.offline_count;
  assign rsp.send_broadcast = res.send_broadcast;
  assign rsp.found          = res.found;
  assign rsp.found_address  = res.found_address;
  assign rsp.found_id       = res.found_id;
  assign rsp.found_state    = res.found_state;

endmodule

@@ sv/nlt_ram.sv @@
// generic single-write, single-read ram with registered read data
module nlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/nlt_ctrl.sv @@
// sequencer: accept, scan the table, commit a discover or status, hand the result over; an echo skips to the hand-over
module nlt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nlt_pkg::ctl_sts_t   sts,
  output nlt_pkg::ctl_cmd_t   cmd
);
  import nlt_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.echo_in ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.rd_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = sts.is_find ? S_WRITE : S_DONE;
      S_WRITE: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:  cmd.rd_en   = 1'b1;
      S_DRAIN: cmd         = '0;
      S_WRITE: cmd.commit  = 1'b1;
      S_DONE:  cmd.publish = sts.out_free;
      default: cmd         = '0;
    endcase
  end

endmodule

@@ sv/nlt_dpath.sv @@
// item registers, config, valid bits, entry ram, scan compare and output register
module nlt_dpath #(
  parameter int TABLE_SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nlt_pkg::ctl_cmd_t             cmd,
  output nlt_pkg::ctl_sts_t             sts,
  input  logic [1:0]                    action,
  input  logic [nlt_pkg::TIME_W-1:0]    now_ms,
  input  logic [nlt_pkg::ADDR_W-1:0]    peer_address,
  input  logic [nlt_pkg::ID_W-1:0]      peer_id,
  input  logic [nlt_pkg::POS_W-1:0]     peer_position,
  input  logic [nlt_pkg::ST_W-1:0]      peer_state,
  input  logic                          cfg_we,
  input  logic [nlt_pkg::CFG_I_W-1:0]   cfg_index,
  input  logic [nlt_pkg::MS_W-1:0]      cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nlt_pkg::result_t              res
);
  import nlt_pkg::*;

  localparam int IDX_W = TABLE_SLOTS > 1 ? $clog2(TABLE_SLOTS) : 1;
  localparam int ENT_W = $bits(entry_t);

  // configuration
  logic [ID_W-1:0] own_id;
  logic [MS_W-1:0] timeout_ms;
  logic [MS_W-1:0] interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id      <= OWN_ID_RST;
      timeout_ms  <= TIMEOUT_RST;
      interval_ms <= INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ID:   own_id      <= cfg_data[ID_W-1:0];
        CFG_TIMEOUT:  timeout_ms  <= cfg_data;
        CFG_INTERVAL: interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched item
  action_t           act;
  logic [TIME_W-1:0] now;
  logic [ADDR_W-1:0] addr;
  logic [ID_W-1:0]   id;
  logic [POS_W-1:0]  pos;
  logic [ST_W-1:0]   pst;
  logic              echo;

  logic echo_in;
  assign echo_in = ((action_t'(action) == ACT_DISCOVER) || (action_t'(action) == ACT_STATUS))
                   && (peer_id == own_id);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action_t'(action);
      now  <= now_ms;
      addr <= peer_address;
      id   <= peer_id;
      pos  <= peer_position;
      pst  <= (peer_state > ST_LAST) ? ST_OFFLINE : peer_state;
      echo <= echo_in;
    end
  end

  // periodic broadcast, decided when a tick is taken
  logic              bc_started;
  logic [TIME_W-1:0] bc_last;
  logic              bc_due;
  logic [TIME_W-1:0] bc_elapsed;

  assign bc_elapsed = now_ms - bc_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bc_started <= 1'b0;
      bc_last    <= '0;
      bc_due     <= 1'b0;
    end else if (cmd.load) begin
      bc_due <= 1'b0;
      if (action_t'(action) == ACT_TICK) begin
        if (!bc_started || (bc_elapsed >= {{(TIME_W-MS_W){1'b0}}, interval_ms})) begin
          bc_started <= 1'b1;
          bc_last    <= now_ms;
          bc_due     <= 1'b1;
        end
      end
    end
  end

  // scan pipeline: a read is issued, and its entry is compared in the cycle after
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_vld;
  logic [TABLE_SLOTS-1:0] vld;
  entry_t           rd_ent;
  logic [ENT_W-1:0] rd_data;

  assign rd_ent = entry_t'(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_idx <= '0;
    end else if (cmd.rd_en) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
    cmp_idx <= rd_idx;
  end

  logic              cur_valid;
  logic [TIME_W-1:0] silent;
  logic              goes_off;

  assign cur_valid = vld[cmp_idx];
  assign silent    = now - rd_ent.heard;
  assign goes_off  = cur_valid && rd_ent.disc && (rd_ent.state != ST_OFFLINE)
                     && (silent > {{(TIME_W-MS_W){1'b0}}, timeout_ms});

  // first match and first free slot
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [ST_W-1:0]   hit_state;
  logic              hit_disc;
  logic [ADDR_W-1:0] hit_addr;
  logic [ID_W-1:0]   hit_id;
  logic              free;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  off_cnt;
  logic              key_match;

  always_comb begin
    key_match = 1'b0;
    case (act)
      ACT_DISCOVER, ACT_STATUS: key_match = cur_valid && (rd_ent.addr == addr);
      ACT_LOOKUP:               key_match = cur_valid && (rd_ent.pos == pos);
      default:                  key_match = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit     <= 1'b0;
      free    <= 1'b0;
      off_cnt <= '0;
    end else if (cmp_vld) begin
      if (key_match && !hit) begin
        hit       <= 1'b1;
        hit_idx   <= cmp_idx;
        hit_state <= rd_ent.state;
        hit_disc  <= rd_ent.disc;
        hit_addr  <= rd_ent.addr;
        hit_id    <= rd_ent.id;
      end
      if (!cur_valid && !free) begin
        free     <= 1'b1;
        free_idx <= cmp_idx;
      end
      if ((act == ACT_TICK) && goes_off && (off_cnt != CNT_MAX)) begin
        off_cnt <= off_cnt + CNT_W'(1);
      end
    end
  end

  // ram write: offline marking during a tick scan, or the find/create commit
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic             do_commit;

  assign do_commit = cmd.commit && (hit || free);

  always_comb begin
    we    = 1'b0;
    waddr = cmp_idx;
    wdata = rd_ent;
    if (cmp_vld && (act == ACT_TICK) && goes_off) begin
      we          = 1'b1;
      wdata.state = ST_OFFLINE;
    end else if (do_commit) begin
      we          = 1'b1;
      waddr       = hit ? hit_idx : free_idx;
      wdata.addr  = addr;
      wdata.id    = id;
      wdata.heard = now;
      if (act == ACT_DISCOVER) begin
        wdata.pos   = pos;
        wdata.state = ST_OK;
        wdata.disc  = 1'b1;
      end else begin
        wdata.pos   = id;
        wdata.state = pst;
        wdata.disc  = hit ? hit_disc : 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (do_commit && !hit) begin
      vld[free_idx] <= 1'b1;
    end
  end

  nlt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // result assembly and output register
  logic              touched;
  logic [IDX_W-1:0]  touch_idx;
  logic [IDX_W+2:0]  touch_wide;
  logic [ST_W-1:0]   prev;
  result_t           res_next;

  assign touched    = hit || free;
  assign touch_idx  = hit ? hit_idx : free_idx;
  assign touch_wide = {3'b000, touch_idx};
  assign prev       = hit ? hit_state : ST_OK;

  always_comb begin
    res_next = '0;
    if (!echo) begin
      case (act)
        ACT_DISCOVER: begin
          res_next.send_reply = 1'b1;
          if (touched) begin
            res_next.accepted       = 1'b1;
            res_next.slot           = touch_wide[SLOT_W-1:0];
            res_next.created        = !hit;
            res_next.previous_state = prev;
          end
        end
        ACT_STATUS: begin
          if (touched) begin
            res_next.accepted       = 1'b1;
            res_next.slot           = touch_wide[SLOT_W-1:0];
            res_next.created        = !hit;
            res_next.previous_state = prev;
            res_next.state_changed  = (prev != pst);
          end
        end
        ACT_TICK: begin
          res_next.offline_count  = off_cnt;
          res_next.send_broadcast = bc_due;
        end
        default: begin
          if (hit) begin
            res_next.accepted      = 1'b1;
            res_next.slot          = touch_wide[SLOT_W-1:0];
            res_next.found         = 1'b1;
            res_next.found_address = hit_addr;
            res_next.found_id      = hit_id;
            res_next.found_state   = hit_state;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res <= res_next;
    end
  end

  assign sts.echo_in  = echo_in;
  assign sts.is_find  = (act == ACT_DISCOVER) || (act == ACT_STATUS);
  assign sts.rd_last  = (rd_idx == IDX_W'(TABLE_SLOTS - 1));
  assign sts.out_free = !out_valid || out_ready;

endmodule
